/* hw/rtl/nmf_pkg.sv */
// ----------------------------------------------------------------------------
// Neighbour mean filter package
// Shared pixel types, register indexes, reset values and the per-channel
// mean of eight neighbouring pixels.
// ----------------------------------------------------------------------------
package nmf_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int CFG_W      = 13;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MIN_SIDE     = 3;

    typedef logic [PIX_W-1:0] t_pixel;

    // One line store entry: the row above and the middle row at one column.
    typedef struct packed {
        t_pixel upper;
        t_pixel middle;
    } t_line_pair;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_index;

    // Truncated mean of eight pixels, channel by channel.
    function automatic t_pixel neighbour_mean(input t_pixel nb [8]);
        logic [CH_W+2:0] sum;
        t_pixel          res;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            sum = '0;
            for (int k = 0; k < 8; k++) begin
                sum = sum + {3'b000, nb[k][ch*CH_W +: CH_W]};
            end
            res[ch*CH_W +: CH_W] = sum[CH_W+2:3];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/neighbor_mean_3x3_rgb_filter_unit.sv */
// ----------------------------------------------------------------------------
// 3x3 neighbour mean RGB filter
// Replaces each interior pixel by the truncated mean of its eight neighbours;
// border pixels pass through unchanged.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the s_axis channel, one item per pixel.
//   s_axis_tuser set marks a drain item that carries no pixel. Each result on
//   m_axis belongs to the pixel W+1 items behind the input (W = image width),
//   so after a frame of W*H pixels the host sends W+1 drain items. The first
//   W+1 items of a frame give no result. m_axis_tlast marks the final pixel.
//   Width and height are written through the cfg port while the block is
//   idle; any write restarts the frame position.
//   Throughput is one item per clock while m_axis takes results. An accepted
//   item waits in the input stage while the line store read completes, and
//   its result then moves into the result register that drives m_axis.
//   The line store is one memory with a single read and a single write port,
//   both used once per item, which sets the rate of one item per cycle.
//   When m_axis stalls, the result register holds and the input stage holds
//   one more item, after which s_axis_tready drops.
//   Reset clears the frame position, the window and the valid flags, and sets
//   width 640 (clamped to MAX_WIDTH) and height 480; the line stores hold
//   no defined data until they are written by the first rows of a frame.
// ----------------------------------------------------------------------------
module neighbor_mean_3x3_rgb_filter_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // Input pixel stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic        s_axis_tuser,   // drain [0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic        m_axis_tlast    // frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = nmf_pkg::CFG_HEIGHT_W;
    // The row position runs up to two past the last row while the tail drains.
    localparam int PW = RW + 1;
    localparam int RESET_W = (nmf_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : nmf_pkg::WIDTH_RESET;
    localparam int CFG_WIDTH_LOC = nmf_pkg::CFG_WIDTH_W;

    // Effective frame size and position of the next input item.
    logic [WW-1:0] r_eff_w, n_eff_w;
    logic [RW-1:0] r_eff_h, n_eff_h;
    logic [CW-1:0] r_col, n_col;
    logic [PW-1:0] r_row, n_row;

    // Input stage.
    logic               r_a_valid;
    nmf_pkg::t_pixel    r_a_px;
    logic [CW-1:0]      r_a_col;
    logic               r_a_emit;
    logic               r_a_border;
    logic               r_a_last;

    // Result register.
    logic               r_out_valid;
    nmf_pkg::t_pixel    r_out_px;
    logic               r_out_last;

    // Window columns one and two; column zero is never needed after a shift.
    nmf_pkg::t_pixel    r_win [3][2];

    logic                in_acc;
    logic                a_adv;
    logic                emit;
    logic                border;
    logic                last;
    logic [PW-1:0]       orow;
    logic [PW-1:0]       h_ext;
    logic [WW-1:0]       ocol;
    logic [WW-1:0]       col_ext;
    logic [CW-1:0]       col_inc;
    logic [CFG_WIDTH_LOC-1:0] cfg_w;
    logic [RW-1:0]       cfg_h;
    nmf_pkg::t_line_pair rd_pair;
    nmf_pkg::t_line_pair wr_pair;
    nmf_pkg::t_pixel     in_px;
    nmf_pkg::t_pixel     nb [8];
    nmf_pkg::t_pixel     mean_px;

    // Handshake: the input stage moves on when the result register is free.
    assign a_adv         = r_a_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || a_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // A drain item enters as a black pixel.
    assign in_px = s_axis_tuser ? '0 : s_axis_tdata;

    // Clamp configuration values to the supported frame size.
    always_comb begin
        cfg_w   = i_cfg_data[CFG_WIDTH_LOC-1:0];
        cfg_h   = i_cfg_data[RW-1:0];
        n_eff_w = r_eff_w;
        n_eff_h = r_eff_h;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                nmf_pkg::REG_IMAGE_WIDTH: begin
                    if (int'(cfg_w) < nmf_pkg::MIN_SIDE) begin
                        n_eff_w = WW'(nmf_pkg::MIN_SIDE);
                    end else if (int'(cfg_w) > MAX_WIDTH) begin
                        n_eff_w = WW'(MAX_WIDTH);
                    end else begin
                        n_eff_w = WW'(cfg_w);
                    end
                end
                nmf_pkg::REG_IMAGE_HEIGHT: begin
                    if (int'(cfg_h) < nmf_pkg::MIN_SIDE) begin
                        n_eff_h = RW'(nmf_pkg::MIN_SIDE);
                    end else begin
                        n_eff_h = cfg_h;
                    end
                end
                default: begin
                    n_eff_w = r_eff_w;
                end
            endcase
        end
    end

    // Output position of the pixel this item completes, and the next position.
    always_comb begin
        col_ext = WW'(r_col);
        col_inc = r_col + 1'b1;
        h_ext   = PW'(r_eff_h);
        emit    = (r_row >= PW'(2)) || ((r_row == PW'(1)) && (r_col != '0));
        if (r_col != '0) begin
            orow = r_row - 1'b1;
            ocol = col_ext - 1'b1;
        end else begin
            orow = r_row - PW'(2);
            ocol = r_eff_w - 1'b1;
        end
        border = (orow == '0) || (orow >= h_ext - 1'b1)
              || (ocol == '0) || (ocol >= r_eff_w - 1'b1);
        last   = (orow == h_ext - 1'b1) && (ocol == r_eff_w - 1'b1);

        if (col_ext + 1'b1 >= r_eff_w) begin
            n_col = '0;
            n_row = r_row + 1'b1;
        end else begin
            n_col = col_inc;
            n_row = r_row;
        end
        if (emit && last) begin
            n_col = '0;
            n_row = '0;
        end
    end

    // Frame size and position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= WW'(RESET_W);
            r_eff_h <= RW'(nmf_pkg::HEIGHT_RESET);
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_eff_w <= n_eff_w;
            r_eff_h <= n_eff_h;
            if (i_cfg_we) begin
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Input stage: pixel and decisions wait for the line store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_px     <= in_px;
            r_a_col    <= r_col;
            r_a_emit   <= emit;
            r_a_border <= border;
            r_a_last   <= last;
        end
    end

    // Line store: the middle row moves up, the new pixel becomes the middle.
    assign wr_pair.upper  = rd_pair.middle;
    assign wr_pair.middle = r_a_px;

    nmf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_pair),
        .i_wr_en   (a_adv),
        .i_wr_addr (r_a_col),
        .i_wr_data (wr_pair)
    );

    // Eight neighbours of the window after the shift; the centre is left out.
    always_comb begin
        nb[0] = r_win[0][0];
        nb[1] = r_win[1][0];
        nb[2] = r_win[2][0];
        nb[3] = r_win[0][1];
        nb[4] = r_win[2][1];
        nb[5] = rd_pair.upper;
        nb[6] = rd_pair.middle;
        nb[7] = r_a_px;
    end

    assign mean_px = nmf_pkg::neighbour_mean(nb);

    // Window shift, one column per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= '0;
                r_win[k][1] <= '0;
            end
        end else if (a_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
            end
            r_win[0][1] <= rd_pair.upper;
            r_win[1][1] <= rd_pair.middle;
            r_win[2][1] <= r_a_px;
        end
    end

    // Result register; a border pixel is the old centre of the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_adv && r_a_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_emit) begin
            r_out_px   <= r_a_border ? r_win[1][1] : mean_px;
            r_out_last <= r_a_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_px;
    assign m_axis_tlast  = r_out_last;

    // The column position always stays inside the row.
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < r_eff_w)
        else $error("column position beyond image width");

    // A full input stage behind a stalled result blocks new items.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the pipeline is full");

    // The item that completes a frame puts the position back to the start.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && emit && last && !i_cfg_we) |=> (r_col == '0 && r_row == '0))
        else $error("frame position not restarted after the last pixel");

    // A result is only produced from an item held in the input stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_a_valid && r_a_emit))
        else $error("result without a source item");

endmodule

/* hw/rtl/nmf_line_store.sv */
// ----------------------------------------------------------------------------
// Line store
// Single memory holding the two buffered rows side by side, one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module nmf_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output nmf_pkg::t_line_pair        o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  nmf_pkg::t_line_pair        i_wr_data
);

    nmf_pkg::t_line_pair r_mem [DEPTH];
    nmf_pkg::t_line_pair r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while no new read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* verif/neighbor_mean_3x3_rgb_filter_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the 3x3 neighbour mean RGB filter
// Sends whole frames of random pixels, drain tails, stray pixels and broken
// frames through the filter with random gaps and stalls on both streams. A
// behavioural copy of the filter predicts every result, and each result is
// compared field by field with the oldest prediction. A short directed table
// at the start covers the smallest frame with the expected pixels typed in.
// ----------------------------------------------------------------------------
module neighbor_mean_3x3_rgb_filter_unit_tb;

    localparam int          CH_W         = nmf_pkg::CH_W;
    localparam int          CFG_W        = nmf_pkg::CFG_W;
    localparam int          CFG_WIDTH_W  = nmf_pkg::CFG_WIDTH_W;
    localparam int          CFG_HEIGHT_W = nmf_pkg::CFG_HEIGHT_W;
    localparam int          MAX_W        = 1024;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          IDLE_SETTLE  = 8;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          DIR_N        = 26;

    typedef struct packed {
        nmf_pkg::t_pixel px;
        logic            last;
    } t_result;

    // One directed item, with the expected result where it is typed in.
    typedef struct packed {
        logic            drain;
        nmf_pkg::t_pixel px;
        logic            typed;
        nmf_pkg::t_pixel want_px;
        logic            want_last;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [12:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red_in [7:0], green_in [15:8], blue_in [23:16]
    logic        s_axis_tuser;   // drain [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // red_out [7:0], green_out [15:8], blue_out [23:16]
    logic        m_axis_tlast;   // frame_last

    neighbor_mean_3x3_rgb_filter_unit #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Filter state as the testbench sees it.
    nmf_pkg::t_pixel         above_line  [MAX_W];
    nmf_pkg::t_pixel         centre_line [MAX_W];
    nmf_pkg::t_pixel         win [3][3];
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;

    t_result     filtered_q [$];
    int unsigned items_done;
    int unsigned fail_count;
    int unsigned cycle_count;
    int          src_mode;
    int          src_left;

    // Smallest frame with typed results, then a frame with an in-frame drain
    // and stray pixels where the drain tail belongs.
    t_dir_row dir_rows [DIR_N] = '{
        '{1'b0, 24'hFF00FF, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'hFF00FF, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'hFF00FF, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'hFF00FF, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'h00FF00, 1'b1, 24'hFF00FF, 1'b0},
        '{1'b0, 24'hFF00FF, 1'b1, 24'hFF00FF, 1'b0},
        '{1'b0, 24'hFF00FF, 1'b1, 24'hFF00FF, 1'b0},
        '{1'b0, 24'hFF00FF, 1'b1, 24'hFF00FF, 1'b0},
        '{1'b0, 24'hFF00FF, 1'b1, 24'hFF00FF, 1'b0},
        '{1'b1, 24'h123456, 1'b1, 24'hFF00FF, 1'b0},
        '{1'b1, 24'h123456, 1'b1, 24'hFF00FF, 1'b0},
        '{1'b1, 24'h123456, 1'b1, 24'hFF00FF, 1'b0},
        '{1'b1, 24'h123456, 1'b1, 24'hFF00FF, 1'b1},
        '{1'b0, 24'h102030, 1'b0, 24'h000000, 1'b0},
        '{1'b1, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'h0A0B0C, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'hF0E0D0, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'h808080, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'h01FE7F, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'h332211, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'hC3A5E7, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'h7F7F7F, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'hABCDEF, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'h000000, 1'b0, 24'h000000, 1'b0},
        '{1'b0, 24'h5A5A5A, 1'b0, 24'h000000, 1'b0}
    };

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a run that hangs ends here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("neighbor_mean_3x3_rgb_filter_unit_tb NOT OK");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (width_reg < nmf_pkg::MIN_SIDE) return nmf_pkg::MIN_SIDE;
        if (width_reg > MAX_W) return MAX_W;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg < nmf_pkg::MIN_SIDE) ? nmf_pkg::MIN_SIDE : 32'(height_reg);
    endfunction

    // Truncated per-channel mean of the eight cells around the window centre.
    function automatic nmf_pkg::t_pixel window_mean();
        int unsigned     sum;
        nmf_pkg::t_pixel res;
        int              ch;
        int              i;
        int              j;
        res = '0;
        for (ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (i = 0; i < 3; i++) begin
                for (j = 0; j < 3; j++) begin
                    if (!(i == 1 && j == 1)) begin
                        sum += 32'(win[i][j][ch*CH_W +: CH_W]);
                    end
                end
            end
            res[ch*CH_W +: CH_W] = CH_W'(sum >> 3);
        end
        return res;
    endfunction

    // Advances the filter by one accepted item and gives the result it causes.
    task automatic filter_step(input nmf_pkg::t_pixel px_in, input logic drain,
                               output logic has_out, output nmf_pkg::t_pixel out_px,
                               output logic out_last);
        int unsigned     w;
        int unsigned     h;
        int unsigned     c;
        int unsigned     r;
        int unsigned     orow;
        int unsigned     ocol;
        nmf_pkg::t_pixel px;
        nmf_pkg::t_pixel top;
        nmf_pkg::t_pixel mid;
        nmf_pkg::t_pixel prev_centre;
        w = eff_width();
        h = eff_height();
        c = col_pos;
        r = row_pos;
        if (c >= w) c = w - 1;
        px = drain ? '0 : px_in;

        // Line stores shift down by one row at this column.
        top = above_line[c];
        mid = centre_line[c];
        above_line[c]  = mid;
        centre_line[c] = px;

        // Window shifts left and takes the new column on the right.
        prev_centre = win[1][2];
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;

        has_out  = 1'b0;
        out_px   = '0;
        out_last = 1'b0;
        if (r >= 2 || (r == 1 && c >= 1)) begin
            if (c >= 1) begin
                orow = r - 1;
                ocol = c - 1;
            end else begin
                orow = r - 2;
                ocol = w - 1;
            end
            if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) begin
                out_px = prev_centre;
            end else begin
                out_px = window_mean();
            end
            out_last = (orow == h - 1 && ocol == w - 1);
            has_out  = 1'b1;
        end

        // The last pixel of a frame puts the position back to the start.
        if (out_last) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
        end
    endtask

    // Register write; called at a falling edge while the filter is idle.
    task automatic write_reg(input nmf_pkg::t_reg_index idx, input logic [CFG_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == nmf_pkg::REG_IMAGE_WIDTH) begin
            width_reg = val[CFG_WIDTH_W-1:0];
        end else begin
            height_reg = val[CFG_HEIGHT_W-1:0];
        end
        col_pos = 0;
        row_pos = 0;
    endtask

    // Offers one item after a random gap and records its prediction once the
    // filter takes it. Called at a falling edge; returns at a falling edge.
    task automatic send_item(input nmf_pkg::t_pixel px, input logic drain,
                             input logic typed, input nmf_pkg::t_pixel want_px,
                             input logic want_last);
        int              gap;
        logic            has_out;
        nmf_pkg::t_pixel out_px;
        logic            out_last;
        t_result         res;
        if (src_left <= 0) begin
            src_mode = $urandom_range(0, 2);
            src_left = $urandom_range(20, 150);
        end
        src_left--;
        case (src_mode)
            0: gap = 0;
            1: begin
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
                if ($urandom_range(0, 49) == 0) gap = $urandom_range(8, 20);
            end
            default: gap = $urandom_range(0, 1);
        endcase
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = px;
        s_axis_tuser  = drain;
        do @(posedge i_clk); while (!s_axis_tready);

        filter_step(px, drain, has_out, out_px, out_last);
        if (has_out) begin
            res.px   = typed ? want_px : out_px;
            res.last = typed ? want_last : out_last;
            filtered_q.push_back(res);
        end
        items_done++;
        @(negedge i_clk);
    endtask

    // Random pixel with the channel extremes made more likely.
    function automatic nmf_pkg::t_pixel rand_pixel();
        nmf_pkg::t_pixel px;
        for (int ch = 0; ch < 3; ch++) begin
            case ($urandom_range(0, 7))
                0: px[ch*CH_W +: CH_W] = '0;
                1: px[ch*CH_W +: CH_W] = '1;
                default: px[ch*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
            endcase
        end
        return px;
    endfunction

    task automatic send_pixels(input int unsigned n, input int drain_pct);
        repeat (n) begin
            send_item(rand_pixel(), ($urandom_range(0, 99) < drain_pct), 1'b0, '0, 1'b0);
        end
    endtask

    // Lets the filter run dry before a register write or the end.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (filtered_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_SETTLE) @(negedge i_clk);
    endtask

    // One random setting of the frame size followed by frames at that size.
    task automatic run_phase();
        logic [CFG_W-1:0] wval;
        logic [CFG_W-1:0] hval;
        int unsigned      w;
        int unsigned      h;
        int               pick;
        int               order;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            wval = CFG_W'($urandom_range(0, 2));
        end else begin
            wval = CFG_W'($urandom_range(3, 12));
        end
        // Bits above the width register are ignored by the filter.
        if ($urandom_range(0, 4) == 0) wval[12:11] = 2'($urandom_range(1, 3));

        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            hval = CFG_W'($urandom_range(0, 2));
        end else if (pick == 1) begin
            case ($urandom_range(0, 2))
                0: hval = 13'd4096;
                1: hval = 13'd8191;
                default: hval = CFG_W'($urandom_range(9, 8191));
            endcase
        end else begin
            hval = CFG_W'($urandom_range(3, 8));
        end

        // A height-only write is kept to phases where the width is already small.
        order = $urandom_range(0, 3);
        if (order == 1 && eff_width() > 12) order = 2;
        case (order)
            0: write_reg(nmf_pkg::REG_IMAGE_WIDTH, wval);
            1: write_reg(nmf_pkg::REG_IMAGE_HEIGHT, hval);
            2: begin
                write_reg(nmf_pkg::REG_IMAGE_WIDTH, wval);
                write_reg(nmf_pkg::REG_IMAGE_HEIGHT, hval);
            end
            default: begin
                write_reg(nmf_pkg::REG_IMAGE_HEIGHT, hval);
                write_reg(nmf_pkg::REG_IMAGE_WIDTH, wval);
            end
        endcase

        w = eff_width();
        h = eff_height();
        if (h > 8) begin
            // Tall frames get at most twelve rows of pixels; the next write restarts the frame.
            send_pixels($urandom_range(2 * w + 2, 12 * w), 5);
        end else begin
            repeat ($urandom_range(1, 3)) begin
                send_pixels(w * h, 2);
                send_pixels(w + 1, 85);
            end
            if ($urandom_range(0, 3) == 0) send_pixels($urandom_range(1, w * h + w), 10);
        end
    endtask

    // Result stream: stretches of steady, lightly and heavily stalled ready.
    initial begin
        int run;
        int mode;
        int stall_left;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            run  = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            repeat (run) begin
                @(negedge i_clk);
                if (stall_left > 0) begin
                    m_axis_tready = 1'b0;
                    stall_left--;
                end else begin
                    case (mode)
                        0: m_axis_tready = 1'b1;
                        1: m_axis_tready = ($urandom_range(0, 3) != 0);
                        2: m_axis_tready = ($urandom_range(0, 9) != 0);
                        default: m_axis_tready = ($urandom_range(0, 1) != 0);
                    endcase
                    if (mode != 0 && $urandom_range(0, 99) == 0) begin
                        stall_left = $urandom_range(8, 20);
                    end
                end
            end
        end
    end

    // Every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (filtered_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: r=%0d g=%0d b=%0d last=%0d",
                             m_axis_tdata[7:0], m_axis_tdata[15:8],
                             m_axis_tdata[23:16], m_axis_tlast);
                end
            end else begin
                want = filtered_q.pop_front();
                if (m_axis_tdata[7:0]   !== want.px[7:0]   ||
                    m_axis_tdata[15:8]  !== want.px[15:8]  ||
                    m_axis_tdata[23:16] !== want.px[23:16] ||
                    m_axis_tlast        !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result mismatch: expected r=%0d g=%0d b=%0d last=%0d, ",
                                 want.px[7:0], want.px[15:8], want.px[23:16], want.last,
                                 "got r=%0d g=%0d b=%0d last=%0d",
                                 m_axis_tdata[7:0], m_axis_tdata[15:8],
                                 m_axis_tdata[23:16], m_axis_tlast);
                    end
                end
            end
        end
    end

    // Main sequence.
    initial begin
        int unsigned base;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = nmf_pkg::REG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        items_done    = 0;
        fail_count    = 0;
        src_mode      = 0;
        src_left      = 0;
        for (int k = 0; k < MAX_W; k++) begin
            above_line[k]  = '0;
            centre_line[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
        width_reg  = CFG_WIDTH_W'(nmf_pkg::WIDTH_RESET);
        height_reg = CFG_HEIGHT_W'(nmf_pkg::HEIGHT_RESET);
        col_pos    = 0;
        row_pos    = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: sizes below the minimum give the smallest frame.
        write_reg(nmf_pkg::REG_IMAGE_WIDTH, 13'd0);
        write_reg(nmf_pkg::REG_IMAGE_HEIGHT, 13'd1);
        for (int k = 0; k < DIR_N; k++) begin
            send_item(dir_rows[k].px, dir_rows[k].drain, dir_rows[k].typed,
                      dir_rows[k].want_px, dir_rows[k].want_last);
        end
        wait_idle();

        // Widest row, clamped from the register, cut short early in the second row.
        write_reg(nmf_pkg::REG_IMAGE_WIDTH, 13'($urandom_range(1024, 2047)));
        write_reg(nmf_pkg::REG_IMAGE_HEIGHT, 13'($urandom_range(3, 6)));
        send_pixels(eff_width() + $urandom_range(10, 40), 2);
        wait_idle();

        // Random phases.
        base = items_done;
        while (items_done - base < RANDOM_ITEMS) begin
            run_phase();
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("neighbor_mean_3x3_rgb_filter_unit_tb OK");
        end else begin
            $display("neighbor_mean_3x3_rgb_filter_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
